// ----- design/lcgbr_pkg.sv -----
`timescale 1ns / 1ps
// Package: widths, generator constants and shared types for the bounded LCG core.
package lcgbr_pkg;

    localparam int STATE_W = 32;
    localparam int BOUND_W = 16;
    localparam int VALUE_W = 15;
    localparam int DIV_W   = 16;

    // Both serial units run 16 steps: 2 multiplier bits per step, 1 quotient bit per step.
    localparam int STEPS   = 16;
    localparam int CNT_W   = 5;

    localparam logic [STATE_W-1:0] LCG_MUL   = 32'd1103515245;
    localparam logic [STATE_W-1:0] LCG_MUL3  = 32'd3310545735;
    localparam logic [STATE_W-1:0] LCG_INC   = 32'd12345;
    localparam logic [STATE_W-1:0] SEED_RST  = 32'd1;
    localparam logic [DIV_W-1:0]   RAW_SPAN  = 16'h8000;
    localparam logic [BOUND_W-1:0] BOUND_MIN = 16'd1;
    localparam logic [CNT_W-1:0]   STEP_INIT = 5'd16;
    localparam logic [CNT_W-1:0]   STEP_LAST = 5'd1;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } div_rsp_t;

endpackage

// ----- design/lcgbr_if.sv -----
`timescale 1ns / 1ps
// Stream interfaces: bound requests in, scaled values out.
interface lcgbr_in_if;
    import lcgbr_pkg::*;

    logic               valid;
    logic               ready;
    logic [BOUND_W-1:0] bound;

    modport source (output valid, output bound, input ready);
    modport sink (input valid, input bound, output ready);
endinterface

interface lcgbr_out_if;
    import lcgbr_pkg::*;

    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink (input valid, input value, output ready);
endinterface

// ----- design/lcgbr_mul.sv -----
`timescale 1ns / 1ps
// Serial LCG step: state * LCG_MUL + LCG_INC, two multiplier bits per cycle.
module lcgbr_mul (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [lcgbr_pkg::STATE_W-1:0]   state_in,
    output logic                            done,
    output logic [lcgbr_pkg::STATE_W-1:0]   product
);
    import lcgbr_pkg::*;

    logic [STATE_W-1:0] acc_reg, acc_next;
    logic [STATE_W-1:0] a1_reg, a1_next;
    logic [STATE_W-1:0] a3_reg, a3_next;
    logic [STATE_W-1:0] m_reg, m_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               done_reg, done_next;
    logic [STATE_W-1:0] addend;

    always_comb
    begin
        case (m_reg[1:0])
            2'b00:   addend = '0;
            2'b01:   addend = a1_reg;
            2'b10:   addend = {a1_reg[STATE_W-2:0], 1'b0};
            2'b11:   addend = a3_reg;
            default: addend = '0;
        endcase
    end

    always_comb
    begin
        acc_next  = acc_reg;
        a1_next   = a1_reg;
        a3_next   = a3_reg;
        m_next    = m_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            acc_next = LCG_INC;
            a1_next  = LCG_MUL;
            a3_next  = LCG_MUL3;
            m_next   = state_in;
            cnt_next = STEP_INIT;
        end
        else if (cnt_reg != '0)
        begin
            // product taken mod 2^32, so the upper carries simply drop off
            acc_next  = acc_reg + addend;
            a1_next   = {a1_reg[STATE_W-3:0], 2'b00};
            a3_next   = {a3_reg[STATE_W-3:0], 2'b00};
            m_next    = {2'b00, m_reg[STATE_W-1:2]};
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == STEP_LAST);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        a1_reg  <= a1_next;
        a3_reg  <= a3_next;
        m_reg   <= m_next;
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

// ----- design/lcgbr_div.sv -----
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle.
module lcgbr_div (
    input  logic                 clk,
    input  logic                 rst_n,
    input  lcgbr_pkg::div_req_t  req,
    output lcgbr_pkg::div_rsp_t  rsp
);
    import lcgbr_pkg::*;

    logic [DIV_W-1:0] rem_reg, rem_next;
    logic [DIV_W-1:0] quo_reg, quo_next;
    logic [DIV_W-1:0] dsr_reg, dsr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             done_reg, done_next;
    logic [DIV_W:0]   shifted;
    logic [DIV_W:0]   diff;
    logic             ge;

    assign shifted = {rem_reg, quo_reg[DIV_W-1]};
    assign diff    = shifted - {1'b0, dsr_reg};
    assign ge      = !diff[DIV_W];

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            rem_next = '0;
            quo_next = req.dividend;
            dsr_next = req.divisor;
            cnt_next = STEP_INIT;
        end
        else if (cnt_reg != '0)
        begin
            // dividend bits shift out the top as quotient bits shift in
            rem_next  = ge ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
            quo_next  = {quo_reg[DIV_W-2:0], ge};
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == STEP_LAST);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// ----- design/lcg_bounded_random_core.sv -----
`timescale 1ns / 1ps
// Top level: bounded draw from an ANSI-style LCG with serial multiply and divide.
//
//   channel   dir   payload                  transfer when
//   in_ch     in    bound [15:0]             valid && ready
//   out_ch    out   value [14:0]             valid && ready
//   cfg       in    cfg_data [31:0] (seed)   cfg_we
//
// A bound above 1 runs the LCG step (2 bits a cycle) beside 32768 / bound,
// then raw / divisor on the same one-bit-a-cycle divider, then loads the
// output register through ST_DONE once that register is free.
// A bound of 0 or 1 returns 0 through ST_DONE, state unchanged.
// Reset loads the generator state with 1. One item in flight; the next is
// accepted while a result still waits in the output register.
module lcg_bounded_random_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [lcgbr_pkg::STATE_W-1:0] cfg_data,
    lcgbr_in_if.sink                      in_ch,
    lcgbr_out_if.source                   out_ch
);
    import lcgbr_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_STEP,
        ST_SCALE,
        ST_DONE
    } fsm_t;

    fsm_t               fsm_reg, fsm_next;
    logic [STATE_W-1:0] lcg_reg, lcg_next;
    logic [VALUE_W-1:0] res_reg, res_next;
    logic [VALUE_W-1:0] value_reg, value_next;
    logic               out_valid_reg, out_valid_next;

    logic               accept;
    logic               draw;
    logic               mul_done;
    logic [STATE_W-1:0] product;
    div_req_t           div_req;
    div_rsp_t           div_rsp;
    logic               slot_free;

    assign in_ch.ready  = (fsm_reg == ST_IDLE);
    assign accept       = in_ch.valid && in_ch.ready;
    assign draw         = accept && (in_ch.bound > BOUND_MIN);
    assign slot_free    = !out_valid_reg || out_ch.ready;
    assign out_ch.valid = out_valid_reg;
    assign out_ch.value = value_reg;

    lcgbr_mul u_mul (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (draw),
        .state_in (lcg_reg),
        .done     (mul_done),
        .product  (product)
    );

    always_comb
    begin
        div_req = '0;
        if (fsm_reg == ST_IDLE)
        begin
            div_req.start    = draw;
            div_req.dividend = RAW_SPAN;
            div_req.divisor  = in_ch.bound;
        end
        else if (fsm_reg == ST_STEP)
        begin
            // raw is bits 30..16 of the new state; divisor = 32768 / bound + 1
            div_req.start    = mul_done;
            div_req.dividend = {1'b0, product[30:16]};
            div_req.divisor  = div_rsp.quotient + 1'b1;
        end
    end

    lcgbr_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_comb
    begin
        fsm_next       = fsm_reg;
        lcg_next       = lcg_reg;
        res_next       = res_reg;
        value_next     = value_reg;
        out_valid_next = out_valid_reg;

        if (out_valid_reg && out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (fsm_reg)
            ST_IDLE:
            begin
                if (cfg_we)
                begin
                    lcg_next = cfg_data;
                end
                if (draw)
                begin
                    fsm_next = ST_STEP;
                end
                else if (accept)
                begin
                    res_next = '0;
                    fsm_next = ST_DONE;
                end
            end
            ST_STEP:
            begin
                if (mul_done)
                begin
                    lcg_next = product;
                    fsm_next = ST_SCALE;
                end
            end
            ST_SCALE:
            begin
                if (div_rsp.done)
                begin
                    res_next = div_rsp.quotient[VALUE_W-1:0];
                    fsm_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (slot_free)
                begin
                    value_next     = res_reg;
                    out_valid_next = 1'b1;
                    fsm_next       = ST_IDLE;
                end
            end
            default:
            begin
                fsm_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fsm_reg       <= ST_IDLE;
            lcg_reg       <= SEED_RST;
            out_valid_reg <= 1'b0;
            res_reg       <= '0;
            value_reg     <= '0;
        end
        else
        begin
            fsm_reg       <= fsm_next;
            lcg_reg       <= lcg_next;
            out_valid_reg <= out_valid_next;
            res_reg       <= res_next;
            value_reg     <= value_next;
        end
    end

endmodule
